// ===== src/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types for the gear shift sequencer: input beat, result beat and the
// configuration bundle handed from the register file to the step logic.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [11:0] position_sample;
    logic        request_write;
    logic        request_value;
  } item_t;

  typedef struct packed {
    logic        post_valid;
    logic [2:0]  post_event;
    logic [6:0]  post_delay;
    logic        dac_write;
    logic [11:0] dac_value;
    logic [3:0]  pdo_mask;
    logic [2:0]  status_code;
    logic        in_transition;
    logic        gear_request;
    logic [2:0]  current_state;
  } result_t;

  typedef struct packed {
    logic [11:0] gear_one_target;
    logic [11:0] gear_two_target;
    logic [11:0] gear_one_min;
    logic [11:0] gear_one_max;
    logic [11:0] gear_two_min;
    logic [11:0] gear_two_max;
    logic [15:0] retry_limit;
  } cfg_t;

endpackage

// ===== src/gear_shift_sequencer.sv =====
// ----------------------------------------------------------------------------
// gear_shift_sequencer
// Two-gear actuator sequencer: one event beat in, one result beat out.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   (item_valid / item_stall / item): one event with the
//     sensed position and an optional gear request write per beat.
//   result channel (result_valid / result_stall / result): exactly one
//     result beat per item beat, in order: self-post event and delay,
//     DAC load, PDO request mask and status.
//   cfg channel    (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//     writes, always ready; indexes beyond the register list are ignored.
//     Write only while no beat is in flight.
// From item acceptance to result_valid a beat passes the input register,
// then the sequencer step feeding the result register. Throughput is one
// beat per cycle while result_stall does not hold a result; the step logic
// is a single pass of compares and muxing between those two registers.
// Reset (rst, synchronous) empties both registers, puts the sequencer in the
// init state and loads the register defaults (retry limit 100, others 0).
// When result_stall is high with a result held, the input register holds
// its beat and item_stall rises until the result drains.
module gear_shift_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  gss_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output gss_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gss_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [gss_pkg::CfgDataWidth-1:0]    cfg_data
);

  gss_pkg::item_t   item_q;
  logic             item_q_valid;
  gss_pkg::cfg_t    cfg;
  gss_pkg::result_t step_res;
  logic             advance;

  // advance the held beat when the result register is free or draining
  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;
  assign cfg_ready  = 1'b1;

  gss_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  gss_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (step_res)
  );

  // input register: take a new beat whenever not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  // result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

endmodule

// ===== src/gss_cfg.sv =====
// ----------------------------------------------------------------------------
// gss_cfg
// Configuration register file: targets, position windows and retry limit.
// ----------------------------------------------------------------------------
module gss_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [gss_pkg::CfgIndexWidth-1:0]   wr_index,
  input  logic [gss_pkg::CfgDataWidth-1:0]    wr_data,
  output gss_pkg::cfg_t                       cfg
);

  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_ONE_TARGET = 3'd0;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_TWO_TARGET = 3'd1;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_TWO_MIN    = 3'd4;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_TWO_MAX    = 3'd5;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_RETRY      = 3'd6;
  localparam logic [15:0] RETRY_RESET = 16'd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gear_one_target <= '0;
      cfg.gear_two_target <= '0;
      cfg.gear_one_min    <= '0;
      cfg.gear_one_max    <= '0;
      cfg.gear_two_min    <= '0;
      cfg.gear_two_max    <= '0;
      cfg.retry_limit     <= RETRY_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ONE_TARGET: cfg.gear_one_target <= wr_data[11:0];
        REG_TWO_TARGET: cfg.gear_two_target <= wr_data[11:0];
        REG_ONE_MIN:    cfg.gear_one_min    <= wr_data[11:0];
        REG_ONE_MAX:    cfg.gear_one_max    <= wr_data[11:0];
        REG_TWO_MIN:    cfg.gear_two_min    <= wr_data[11:0];
        REG_TWO_MAX:    cfg.gear_two_max    <= wr_data[11:0];
        REG_RETRY:      cfg.retry_limit     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/gss_core.sv =====
// ----------------------------------------------------------------------------
// gss_core
// Sequencer state and one-step logic: transition table, entry and loop
// actions. State advances on each step strobe.
// ----------------------------------------------------------------------------
module gss_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  gss_pkg::item_t   item,
  input  gss_pkg::cfg_t    cfg,
  output gss_pkg::result_t res
);

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_GO1     = 3'd1,
    MODE_GO2     = 3'd2,
    MODE_REACHED = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  localparam logic [2:0] EV_INIT    = 3'd0;
  localparam logic [2:0] EV_REACHED = 3'd1;
  localparam logic [2:0] EV_GO1     = 3'd2;
  localparam logic [2:0] EV_GO2     = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  localparam logic [6:0] DELAY_SHORT = 7'd10;
  localparam logic [6:0] DELAY_LONG  = 7'd100;

  localparam logic [2:0] STATUS_GO1     = 3'd2;
  localparam logic [2:0] STATUS_GO2     = 3'd3;
  localparam logic [2:0] STATUS_REACHED = 3'd4;
  localparam logic [2:0] STATUS_ERROR   = 3'd6;

  localparam logic [3:0] MASK_SHIFT = 4'hA;
  localparam logic [3:0] MASK_HOLD  = 4'hB;
  localparam logic [3:0] MASK_LOOP  = 4'hC;

  mode_t       mode, mode_next;
  logic        ack, ack_next;
  logic        sreq, sreq_next, sreq_in;
  logic [15:0] retry, retry_next, retry_inc;
  logic        tflag, tflag_next;
  logic [2:0]  status, status_next;
  logic        win1, win2, win_sel, one;

  always_comb begin
    sreq_in   = item.request_write ? item.request_value : sreq;
    win1      = (item.position_sample >= cfg.gear_one_min) &&
                (item.position_sample <= cfg.gear_one_max);
    win2      = (item.position_sample >= cfg.gear_two_min) &&
                (item.position_sample <= cfg.gear_two_max);
    retry_inc = retry + 16'd1;

    // transition table; unlisted events leave the mode alone
    mode_next = mode;
    unique case (mode)
      MODE_INIT: begin
        if (item.event_code == EV_INIT) mode_next = MODE_GO1;
      end
      MODE_GO1: begin
        if (item.event_code == EV_REACHED)    mode_next = MODE_REACHED;
        else if (item.event_code == EV_GO2)   mode_next = MODE_GO2;
        else if (item.event_code == EV_ERROR) mode_next = MODE_ERROR;
      end
      MODE_GO2: begin
        if (item.event_code == EV_REACHED)    mode_next = MODE_REACHED;
        else if (item.event_code == EV_GO1)   mode_next = MODE_GO1;
        else if (item.event_code == EV_ERROR) mode_next = MODE_ERROR;
      end
      MODE_REACHED: begin
        if (item.event_code == EV_GO1)        mode_next = MODE_GO1;
        else if (item.event_code == EV_GO2)   mode_next = MODE_GO2;
        else if (item.event_code == EV_ERROR) mode_next = MODE_ERROR;
      end
      default: begin
        if (item.event_code == EV_REACHED)    mode_next = MODE_REACHED;
        else if (item.event_code == EV_GO1)   mode_next = MODE_GO1;
        else if (item.event_code == EV_GO2)   mode_next = MODE_GO2;
        else if (item.event_code == EV_INIT)  mode_next = MODE_INIT;
      end
    endcase

    res         = '0;
    ack_next    = ack;
    sreq_next   = sreq_in;
    retry_next  = retry;
    tflag_next  = tflag;
    status_next = status;
    one         = (mode_next == MODE_GO1);
    win_sel     = one ? win1 : win2;

    if (mode_next != mode) begin
      // entry actions
      unique case (mode_next)
        MODE_INIT: begin
          res.post_valid = 1'b1;
          res.post_event = EV_INIT;
          res.post_delay = DELAY_SHORT;
        end
        MODE_GO1, MODE_GO2: begin
          status_next   = one ? STATUS_GO1 : STATUS_GO2;
          ack_next      = sreq_in;
          tflag_next    = 1'b1;
          retry_next    = '0;
          res.pdo_mask  = MASK_SHIFT;
          res.dac_write = 1'b1;
          res.dac_value = one ? cfg.gear_one_target : cfg.gear_two_target;
          res.post_valid = 1'b1;
          if (win_sel) begin
            res.post_event = EV_REACHED;
            res.post_delay = DELAY_LONG;
          end else begin
            res.post_event = one ? EV_GO1 : EV_GO2;
            res.post_delay = DELAY_SHORT;
          end
        end
        MODE_REACHED: begin
          status_next    = STATUS_REACHED;
          retry_next     = '0;
          tflag_next     = 1'b0;
          res.pdo_mask   = MASK_HOLD;
          res.post_valid = 1'b1;
          res.post_event = EV_REACHED;
          res.post_delay = DELAY_LONG;
        end
        default: begin
          // error: flip the request and head for the other gear
          status_next    = STATUS_ERROR;
          tflag_next     = 1'b1;
          sreq_next      = ~sreq_in;
          ack_next       = ~sreq_in;
          res.pdo_mask   = MASK_HOLD;
          res.post_valid = 1'b1;
          res.post_event = sreq_in ? EV_GO1 : EV_GO2;
          res.post_delay = DELAY_LONG;
        end
      endcase
    end else begin
      // loop actions
      unique case (mode)
        MODE_INIT: ;
        MODE_GO1, MODE_GO2: begin
          res.pdo_mask   = MASK_LOOP;
          retry_next     = retry_inc;
          res.post_valid = 1'b1;
          priority if (win_sel) begin
            res.post_event = EV_REACHED;
            res.post_delay = DELAY_LONG;
          end else if (one && sreq_in) begin
            res.post_event = EV_GO2;
            res.post_delay = DELAY_LONG;
          end else if (!one && !sreq_in) begin
            res.post_event = EV_GO1;
            res.post_delay = DELAY_SHORT;
          end else if (retry_inc == cfg.retry_limit) begin
            retry_next     = '0;
            res.post_event = EV_ERROR;
            res.post_delay = DELAY_LONG;
          end else begin
            res.post_event = one ? EV_GO1 : EV_GO2;
            res.post_delay = DELAY_SHORT;
          end
        end
        MODE_REACHED: begin
          res.post_valid = 1'b1;
          res.post_delay = DELAY_LONG;
          if (sreq_in != ack) begin
            ack_next       = sreq_in;
            res.pdo_mask   = MASK_LOOP | 4'h1;
            res.post_event = sreq_in ? EV_GO2 : EV_GO1;
          end else begin
            res.pdo_mask   = MASK_LOOP;
            res.post_event = EV_REACHED;
          end
        end
        default: begin
          res.post_valid = 1'b1;
          res.post_event = EV_INIT;
          res.post_delay = DELAY_SHORT;
        end
      endcase
    end

    res.status_code   = status_next;
    res.in_transition = tflag_next;
    res.gear_request  = sreq_next;
    res.current_state = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_INIT;
      ack    <= 1'b0;
      sreq   <= 1'b0;
      retry  <= '0;
      tflag  <= 1'b0;
      status <= '0;
    end else if (step) begin
      mode   <= mode_next;
      ack    <= ack_next;
      sreq   <= sreq_next;
      retry  <= retry_next;
      tflag  <= tflag_next;
      status <= status_next;
    end
  end

endmodule

// ===== verif/tb_gear_shift_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gear_shift_sequencer
// Self-checking bench for the two-gear actuator sequencer. A predictor steps
// its own copy of the state machine for every accepted event beat. Each
// result beat is checked field by field against the oldest prediction. A short
// directed walk through every state and special case comes first. After it
// come phases of random event traffic, each phase under its own register
// setting, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_gear_shift_sequencer;

  // State codes, as reported on current_state
  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_GO_ONE  = 3'd1;
  localparam logic [2:0] ST_GO_TWO  = 3'd2;
  localparam logic [2:0] ST_REACHED = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  // Event codes; the last three match no transition
  localparam logic [2:0] EV_INIT      = 3'd0;
  localparam logic [2:0] EV_REACHED   = 3'd1;
  localparam logic [2:0] EV_GO_ONE    = 3'd2;
  localparam logic [2:0] EV_GO_TWO    = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;
  localparam logic [2:0] EV_UNKNOWN_A = 3'd5;
  localparam logic [2:0] EV_UNKNOWN_B = 3'd6;
  localparam logic [2:0] EV_UNKNOWN_C = 3'd7;

  localparam logic [6:0] DELAY_SHORT = 7'd10;
  localparam logic [6:0] DELAY_LONG  = 7'd100;

  localparam logic [2:0] STATUS_GEAR_ONE = 3'd2;
  localparam logic [2:0] STATUS_GEAR_TWO = 3'd3;
  localparam logic [2:0] STATUS_REACHED  = 3'd4;
  localparam logic [2:0] STATUS_ERROR    = 3'd6;

  // PDO request masks
  localparam logic [3:0] PDO_SHIFT_ENTRY = 4'hA;
  localparam logic [3:0] PDO_HOLD_ENTRY  = 4'hB;
  localparam logic [3:0] PDO_LOOP        = 4'hC;
  localparam logic [3:0] PDO_REQUEST_ACK = 4'h1;

  // Register indexes
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_GEAR_ONE_TARGET = 3'd0;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_GEAR_TWO_TARGET = 3'd1;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_GEAR_ONE_MIN    = 3'd2;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_GEAR_ONE_MAX    = 3'd3;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_GEAR_TWO_MIN    = 3'd4;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_GEAR_TWO_MAX    = 3'd5;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_RETRY_LIMIT     = 3'd6;
  localparam logic [gss_pkg::CfgIndexWidth-1:0] REG_UNUSED          = 3'd7;

  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BEATS_PER_PHASE = 200;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic                                clk          = 1'b0;
  logic                                rst          = 1'b1;
  logic                                item_valid   = 1'b0;
  logic                                item_stall;
  gss_pkg::item_t                      item         = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  gss_pkg::result_t                    result;
  logic                                cfg_valid    = 1'b0;
  logic                                cfg_ready;
  logic [gss_pkg::CfgIndexWidth-1:0]   cfg_index    = '0;
  logic [gss_pkg::CfgDataWidth-1:0]    cfg_data     = '0;

  // Predictor copy of the sequencer state and registers
  gss_pkg::cfg_t gear_cfg;
  logic [2:0]  seq_mode      = ST_INIT;
  logic [2:0]  seq_prev_mode = ST_INIT;
  logic        ack_request   = 1'b0;
  logic        held_request  = 1'b0;
  logic [15:0] retries       = '0;
  logic        shifting      = 1'b0;
  logic [2:0]  status_reg    = '0;

  gss_pkg::item_t   event_backlog[$];
  gss_pkg::result_t predicted_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          steady_flow    = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;

  gear_shift_sequencer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gear_shift_sequencer: mismatch");
      $finish;
    end
  end

  // Idle length before the next beat on either side; none in steady phases
  function automatic int unsigned pause_draw();
    if (steady_flow || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Advance the predicted sequencer by one event beat and build its report
  function automatic gss_pkg::result_t sequencer_step(gss_pkg::item_t beat);
    gss_pkg::result_t rep;
    logic [2:0]  nxt;
    logic        one;
    logic        hit;
    rep = '0;
    if (beat.request_write) held_request = beat.request_value;

    // Transition table; anything not listed holds the state
    nxt = seq_mode;
    case (seq_mode)
      ST_INIT: begin
        if (beat.event_code == EV_INIT) nxt = ST_GO_ONE;
      end
      ST_GO_ONE: begin
        case (beat.event_code)
          EV_REACHED: nxt = ST_REACHED;
          EV_GO_TWO:  nxt = ST_GO_TWO;
          EV_ERROR:   nxt = ST_ERROR;
          default: ;
        endcase
      end
      ST_GO_TWO: begin
        case (beat.event_code)
          EV_REACHED: nxt = ST_REACHED;
          EV_GO_ONE:  nxt = ST_GO_ONE;
          EV_ERROR:   nxt = ST_ERROR;
          default: ;
        endcase
      end
      ST_REACHED: begin
        case (beat.event_code)
          EV_GO_ONE: nxt = ST_GO_ONE;
          EV_GO_TWO: nxt = ST_GO_TWO;
          EV_ERROR:  nxt = ST_ERROR;
          default: ;
        endcase
      end
      default: begin
        case (beat.event_code)
          EV_REACHED: nxt = ST_REACHED;
          EV_GO_ONE:  nxt = ST_GO_ONE;
          EV_GO_TWO:  nxt = ST_GO_TWO;
          EV_INIT:    nxt = ST_INIT;
          default: ;
        endcase
      end
    endcase
    seq_mode = nxt;

    // Inclusive window; an inverted window never matches
    one = (seq_mode == ST_GO_ONE);
    hit = one ? (beat.position_sample >= gear_cfg.gear_one_min &&
                 beat.position_sample <= gear_cfg.gear_one_max)
              : (beat.position_sample >= gear_cfg.gear_two_min &&
                 beat.position_sample <= gear_cfg.gear_two_max);

    if (seq_mode != seq_prev_mode) begin
      // Entry actions
      seq_prev_mode = seq_mode;
      case (seq_mode)
        ST_INIT: begin
          rep.post_valid = 1'b1;
          rep.post_event = EV_INIT;
          rep.post_delay = DELAY_SHORT;
        end
        ST_GO_ONE, ST_GO_TWO: begin
          status_reg    = one ? STATUS_GEAR_ONE : STATUS_GEAR_TWO;
          ack_request   = held_request;
          shifting      = 1'b1;
          retries       = '0;
          rep.pdo_mask  = PDO_SHIFT_ENTRY;
          rep.dac_write = 1'b1;
          rep.dac_value = one ? gear_cfg.gear_one_target : gear_cfg.gear_two_target;
          rep.post_valid = 1'b1;
          if (hit) begin
            rep.post_event = EV_REACHED;
            rep.post_delay = DELAY_LONG;
          end else begin
            rep.post_event = one ? EV_GO_ONE : EV_GO_TWO;
            rep.post_delay = DELAY_SHORT;
          end
        end
        ST_REACHED: begin
          status_reg     = STATUS_REACHED;
          retries        = '0;
          shifting       = 1'b0;
          rep.pdo_mask   = PDO_HOLD_ENTRY;
          rep.post_valid = 1'b1;
          rep.post_event = EV_REACHED;
          rep.post_delay = DELAY_LONG;
        end
        default: begin
          // Error entry flips the request and heads for the other gear
          status_reg     = STATUS_ERROR;
          shifting       = 1'b1;
          held_request   = ~held_request;
          ack_request    = held_request;
          rep.pdo_mask   = PDO_HOLD_ENTRY;
          rep.post_valid = 1'b1;
          rep.post_event = held_request ? EV_GO_TWO : EV_GO_ONE;
          rep.post_delay = DELAY_LONG;
        end
      endcase
    end else begin
      // Loop actions
      case (seq_mode)
        ST_INIT: ;
        ST_GO_ONE, ST_GO_TWO: begin
          rep.pdo_mask   = PDO_LOOP;
          retries        = retries + 16'd1;
          rep.post_valid = 1'b1;
          if (hit) begin
            rep.post_event = EV_REACHED;
            rep.post_delay = DELAY_LONG;
          end else if (one && held_request) begin
            rep.post_event = EV_GO_TWO;
            rep.post_delay = DELAY_LONG;
          end else if (!one && !held_request) begin
            rep.post_event = EV_GO_ONE;
            rep.post_delay = DELAY_SHORT;
          end else if (retries == gear_cfg.retry_limit) begin
            retries        = '0;
            rep.post_event = EV_ERROR;
            rep.post_delay = DELAY_LONG;
          end else begin
            rep.post_event = one ? EV_GO_ONE : EV_GO_TWO;
            rep.post_delay = DELAY_SHORT;
          end
        end
        ST_REACHED: begin
          rep.pdo_mask   = PDO_LOOP;
          rep.post_valid = 1'b1;
          rep.post_delay = DELAY_LONG;
          if (held_request != ack_request) begin
            ack_request    = held_request;
            rep.pdo_mask   = PDO_LOOP | PDO_REQUEST_ACK;
            rep.post_event = held_request ? EV_GO_TWO : EV_GO_ONE;
          end else begin
            rep.post_event = EV_REACHED;
          end
        end
        default: begin
          rep.post_valid = 1'b1;
          rep.post_event = EV_INIT;
          rep.post_delay = DELAY_SHORT;
        end
      endcase
    end

    rep.status_code   = status_reg;
    rep.in_transition = shifting;
    rep.gear_request  = held_request;
    rep.current_state = seq_mode;
    return rep;
  endfunction

  // Event driver: present queued beats, hold while stalled, idle between beats
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = item_valid;
      if (item_valid && !item_stall) begin
        predicted_reports.push_back(sequencer_step(item));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (event_backlog.size() != 0) begin
          item <= event_backlog.pop_front();
          next_valid = 1'b1;
          send_gap = pause_draw();
        end
      end
      item_valid <= next_valid;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result monitor: check each accepted beat, stall at random between beats
  always @(posedge clk) begin
    gss_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_reports.size() == 0) begin
          $error("result beat arrived with no prediction pending");
          mismatch_count++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("post_valid",    want.post_valid,    result.post_valid);
          check_field("post_event",    want.post_event,    result.post_event);
          check_field("post_delay",    want.post_delay,    result.post_delay);
          check_field("dac_write",     want.dac_write,     result.dac_write);
          check_field("dac_value",     want.dac_value,     result.dac_value);
          check_field("pdo_mask",      want.pdo_mask,      result.pdo_mask);
          check_field("status_code",   want.status_code,   result.status_code);
          check_field("in_transition", want.in_transition, result.in_transition);
          check_field("gear_request",  want.gear_request,  result.gear_request);
          check_field("current_state", want.current_state, result.current_state);
        end
        recv_gap = pause_draw();
      end
      if (recv_gap != 0) begin
        result_stall <= 1'b1;
        recv_gap--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Leaves cfg_valid high so back-to-back writes never drop it mid-step;
  // the caller lowers it after the last write.
  task automatic write_reg(input logic [gss_pkg::CfgIndexWidth-1:0] idx,
                           input logic [gss_pkg::CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GEAR_ONE_TARGET: gear_cfg.gear_one_target = data[11:0];
      REG_GEAR_TWO_TARGET: gear_cfg.gear_two_target = data[11:0];
      REG_GEAR_ONE_MIN:    gear_cfg.gear_one_min    = data[11:0];
      REG_GEAR_ONE_MAX:    gear_cfg.gear_one_max    = data[11:0];
      REG_GEAR_TWO_MIN:    gear_cfg.gear_two_min    = data[11:0];
      REG_GEAR_TWO_MAX:    gear_cfg.gear_two_max    = data[11:0];
      REG_RETRY_LIMIT:     gear_cfg.retry_limit     = data;
      default: ;
    endcase
  endtask

  // Load all registers; junk in the upper data bits must be dropped
  task automatic load_setting(input logic [11:0] t1, input logic [11:0] t2,
                              input logic [11:0] lo1, input logic [11:0] hi1,
                              input logic [11:0] lo2, input logic [11:0] hi2,
                              input logic [15:0] limit);
    write_reg(REG_GEAR_ONE_TARGET, {4'($urandom), t1});
    write_reg(REG_GEAR_TWO_TARGET, {4'($urandom), t2});
    write_reg(REG_GEAR_ONE_MIN,    {4'($urandom), lo1});
    write_reg(REG_GEAR_ONE_MAX,    {4'($urandom), hi1});
    write_reg(REG_GEAR_TWO_MIN,    {4'($urandom), lo2});
    write_reg(REG_GEAR_TWO_MAX,    {4'($urandom), hi2});
    write_reg(REG_RETRY_LIMIT,     limit);
    // An out-of-range index must leave every register alone
    write_reg(REG_UNUSED,          16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_beat(input logic [2:0] ev, input logic [11:0] pos,
                          input logic wr, input logic val);
    gss_pkg::item_t beat;
    beat.event_code      = ev;
    beat.position_sample = pos;
    beat.request_write   = wr;
    beat.request_value   = val;
    event_backlog.push_back(beat);
  endtask

  // Wait until every beat is sent and answered, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (event_backlog.size() != 0 || item_valid || predicted_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bias positions toward the windows and their edges
  function automatic logic [11:0] draw_position();
    logic [11:0] lo;
    logic [11:0] hi;
    if ($urandom_range(0, 1)) begin
      lo = gear_cfg.gear_one_min;
      hi = gear_cfg.gear_one_max;
    end else begin
      lo = gear_cfg.gear_two_min;
      hi = gear_cfg.gear_two_max;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return (lo <= hi) ? 12'($urandom_range(hi, lo)) : 12'($urandom);
      4:       return lo;
      5:       return hi;
      6:       return lo - 12'd1;
      7:       return hi + 12'd1;
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned queued;
    int unsigned run;
    logic [11:0] t1, t2, lo1, hi1, lo2, hi2, swap;
    logic [15:0] limit;
    logic [2:0]  ev;

    gear_cfg = '0;
    gear_cfg.retry_limit = 16'd100;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: narrow windows, retry limit two
    load_setting(12'hABC, 12'h543, 12'd100, 12'd200, 12'd3000, 12'd3100, 16'd2);
    add_beat(EV_REACHED,   12'd0,    1'b0, 1'b0); // init ignores all but init
    add_beat(EV_UNKNOWN_C, 12'd4095, 1'b0, 1'b0); // unknown code holds
    add_beat(EV_INIT,      12'd150,  1'b0, 1'b0); // enter gear one, in window
    add_beat(EV_INIT,      12'd150,  1'b0, 1'b0); // loop, in window
    add_beat(EV_UNKNOWN_B, 12'd50,   1'b0, 1'b0); // second pass hits retry limit
    add_beat(EV_UNKNOWN_A, 12'd4095, 1'b0, 1'b0); // keep going to gear one
    add_beat(EV_INIT,      12'd99,   1'b1, 1'b1); // request gear two
    add_beat(EV_GO_TWO,    12'd3050, 1'b0, 1'b0); // enter gear two, in window
    add_beat(EV_INIT,      12'd0,    1'b0, 1'b0); // keep going to gear two
    add_beat(EV_INIT,      12'd2999, 1'b1, 1'b0); // request back to gear one
    add_beat(EV_REACHED,   12'd201,  1'b0, 1'b0); // enter reached
    add_beat(EV_UNKNOWN_A, 12'd0,    1'b0, 1'b0); // acknowledge changed request
    add_beat(EV_INIT,      12'd0,    1'b0, 1'b0); // steady reached
    add_beat(EV_GO_ONE,    12'd4095, 1'b0, 1'b0); // enter gear one, outside
    add_beat(EV_ERROR,     12'd0,    1'b0, 1'b0); // error flips request
    add_beat(EV_INIT,      12'd0,    1'b0, 1'b0); // error back to init
    add_beat(EV_GO_TWO,    12'd0,    1'b0, 1'b0); // init ignores go two
    add_beat(EV_INIT,      12'd200,  1'b0, 1'b0); // enter gear one, window top
    add_beat(EV_ERROR,     12'd0,    1'b0, 1'b0);
    add_beat(EV_UNKNOWN_B, 12'd0,    1'b0, 1'b0); // error loop posts init
    add_beat(EV_GO_TWO,    12'd3100, 1'b0, 1'b0); // error to gear two, edge
    add_beat(EV_ERROR,     12'd3101, 1'b0, 1'b0);
    add_beat(EV_REACHED,   12'd0,    1'b1, 1'b1); // error to reached
    add_beat(EV_ERROR,     12'd0,    1'b0, 1'b0);
    add_beat(EV_GO_ONE,    12'd100,  1'b0, 1'b0); // error to gear one, bottom
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      t1    = 12'($urandom);
      t2    = 12'($urandom);
      lo1   = 12'($urandom_range(0, 3400));
      hi1   = lo1 + 12'($urandom_range(0, 695));
      lo2   = 12'($urandom_range(0, 3400));
      hi2   = lo2 + 12'($urandom_range(0, 695));
      limit = 16'($urandom_range(1, 4));
      case (phase)
        0: begin
          // Everything inside both windows, DAC at full scale, shortest limit
          t1 = 12'hFFF; t2 = 12'hFFF;
          lo1 = '0; hi1 = 12'hFFF; lo2 = '0; hi2 = 12'hFFF;
          limit = 16'd1;
        end
        1: begin
          // Inverted windows never match; longest limit
          t1 = '0; t2 = '0;
          lo1 = 12'hFFF; hi1 = '0; lo2 = 12'd2000; hi2 = 12'd1999;
          limit = 16'hFFFF;
        end
        2: limit = '0; // only a full wrap of the count would match
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            swap = lo1; lo1 = hi1; hi1 = swap;
          end
        end
      endcase
      load_setting(t1, t2, lo1, hi1, lo2, hi2, limit);
      steady_flow = (phase == 4);

      queued = 0;
      while (queued < BEATS_PER_PHASE) begin
        if ($urandom_range(0, 2) == 0) begin
          // Dwell in the current state: unknown codes, some init, mostly off-window
          run = $urandom_range(1, 8);
          repeat (run) begin
            ev = $urandom_range(0, 3) == 0 ? EV_INIT
                                           : 3'($urandom_range(EV_UNKNOWN_A, EV_UNKNOWN_C));
            add_beat(ev, $urandom_range(0, 2) != 0 ? 12'($urandom) : draw_position(),
                     $urandom_range(0, 7) == 0, 1'($urandom));
          end
          queued += run;
        end else begin
          ev = $urandom_range(0, 9) == 0 ? 3'($urandom_range(EV_UNKNOWN_A, EV_UNKNOWN_C))
                                         : 3'($urandom_range(EV_INIT, EV_ERROR));
          add_beat(ev, draw_position(), $urandom_range(0, 3) == 0, 1'($urandom));
          queued++;
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("gear_shift_sequencer: match");
    end else begin
      $display("gear_shift_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gss_pkg.sv
src/gss_cfg.sv
src/gss_core.sv
src/gear_shift_sequencer.sv
verif/tb_gear_shift_sequencer.sv
